>>> rtl/core/imu_cf_pkg.sv
// shared types, constants and arithmetic helpers of the attitude filter
`timescale 1ns / 1ps

package imu_cf_pkg;

	// cordic set-up
	localparam int CORDIC_ITERS_DEF = 16;
	localparam int ATAN_LEN = 24;
	localparam int ATAN_IDX_W = 5;
	localparam int ATAN_W = 22;

	// datapath widths
	localparam int CW = 27;        // cordic x, y and z
	localparam int RAD_W = 48;     // radicand of the magnitude root
	localparam int ROOT_W = 24;    // magnitude root
	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = 34;
	localparam int PROD_W = 52;
	localparam int SUM_W = 53;
	localparam int INC_W = 26;     // gyro increment, q16 degrees
	localparam int PRED_W = 33;    // angle plus increment
	localparam int SQ_W = 32;      // ay^2 + az^2

	localparam logic [16:0] ALPHA_ONE = 17'd65536;
	localparam logic [16:0] ALPHA_RESET = 17'd64225;
	localparam logic [15:0] GAIN_RESET = 16'd5115;
	localparam logic signed [CW-1:0] DEG180 = 27'sd11796480;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN = 1'b1;

	// status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// atan(2^-i) in q16 degrees, rounded to nearest
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] r;
		unique case (idx)
			5'd0: r = 22'd2949120;
			5'd1: r = 22'd1740967;
			5'd2: r = 22'd919879;
			5'd3: r = 22'd466945;
			5'd4: r = 22'd234379;
			5'd5: r = 22'd117304;
			5'd6: r = 22'd58666;
			5'd7: r = 22'd29335;
			5'd8: r = 22'd14668;
			5'd9: r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			5'd22: r = 22'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// q24 gyro product to q16, round half up
	function automatic logic signed [INC_W-1:0] rnd_inc(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + 52'sd128;
		return $signed(t[INC_W+7:8]);
	endfunction

	// q32 blend sum to q16, round half up, saturate to 32 bits
	function automatic logic signed [31:0] sat_rnd16(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] t;
		logic signed [36:0] s;
		logic signed [31:0] r;
		t = v + 53'sd32768;
		s = 37'(t >>> 16);
		if (s > 37'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (s < -37'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	// saturating add of an increment to a 32-bit angle
	function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
			input logic signed [INC_W-1:0] b);
		logic signed [32:0] s;
		logic signed [31:0] r;
		s = {a[31], a} + {{(33-INC_W){b[INC_W-1]}}, b};
		if (s[32] != s[31]) begin
			r = s[32] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/imu_cf_isqrt.sv
// bit-serial floor square root, one result bit per cycle
`timescale 1ns / 1ps

module imu_cf_isqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [imu_cf_pkg::RAD_W-1:0]        rad_in,
	output logic [imu_cf_pkg::ROOT_W-1:0]       root_out,
	output imu_cf_pkg::unit_sts_t               sts
);

	localparam int RW = imu_cf_pkg::ROOT_W;
	localparam int CNT_W = $clog2(RW);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(RW - 1);

	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [imu_cf_pkg::RAD_W-1:0] rad_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;

	always_comb begin
		rem_sh = {rem_q[RW-1:0], rad_q[imu_cf_pkg::RAD_W-1 -: 2]};
		trial = {root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= rad_in;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[imu_cf_pkg::RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign root_out = root_q;
	assign sts = '{busy: busy_q, done: done_q};

endmodule

>>> rtl/core/imu_cf_cordic.sv
// iterative vectoring cordic, atan2 in q16 degrees, one rotation per cycle
`timescale 1ns / 1ps

module imu_cf_cordic #(
	parameter int ITERS = imu_cf_pkg::CORDIC_ITERS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [imu_cf_pkg::CW-1:0]    y_in,
	input  logic signed [imu_cf_pkg::CW-1:0]    x_in,
	output logic signed [imu_cf_pkg::CW-1:0]    z_out,
	output imu_cf_pkg::unit_sts_t               sts
);

	localparam int CW = imu_cf_pkg::CW;
	localparam int NI = (ITERS > imu_cf_pkg::ATAN_LEN) ? imu_cf_pkg::ATAN_LEN : ITERS;
	localparam int IW = $clog2(NI);
	localparam logic [IW-1:0] LAST = IW'(NI - 1);

	logic [IW-1:0] iter_q;
	logic busy_q;
	logic done_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [CW-1:0] z_q;

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] at;
	logic zero_vec;

	always_comb begin
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		at = $signed(CW'(imu_cf_pkg::atan_q16(imu_cf_pkg::ATAN_IDX_W'(iter_q))));
		zero_vec = (x_in == '0) && (y_in == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			// a zero vector answers at once with zero
			iter_q <= '0;
			busy_q <= !zero_vec;
			done_q <= zero_vec;
		end else if (busy_q) begin
			if (iter_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (zero_vec) begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end else if (x_in[CW-1]) begin
				// left half plane folds by half a turn
				x_q <= -x_in;
				y_q <= -y_in;
				z_q <= y_in[CW-1] ? -imu_cf_pkg::DEG180 : imu_cf_pkg::DEG180;
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign z_out = z_q;
	assign sts = '{busy: busy_q, done: done_q};

endmodule

>>> rtl/core/imu_complementary_attitude_filter.sv
// top level of the six-axis complementary attitude filter
`timescale 1ns / 1ps

// usage
// - input channel in_valid/in_ready takes one raw sample item: accel_x/y/z and
//   gyro_x/y/z, signed 16-bit each
// - output channel out_valid/out_ready gives pitch_deg, roll_deg, yaw_deg,
//   signed q15.16 degrees, one result item per sample item
// - cfg_valid/cfg_ready/cfg_index/cfg_data writes blend_alpha (index 0) and
//   gyro_step_gain (index 1); cfg_ready is always high, write only while idle
// - an item goes through the 24-step magnitude root, run beside the pitch
//   cordic, then the roll cordic on the shared rotation unit, plus
//   shared-multiplier passes for squares, gyro increments and the blend;
//   the next item is taken only once this one has reached the output register
// - in_ready is high only in the idle state
// - a finished result sits in the output register; the next item may be taken
//   and worked on while it waits, and is held at the end until the slot frees
// - reset clears the three angles, loads the default alpha and gain and
//   leaves the output channel empty

module imu_complementary_attitude_filter #(
	parameter int CORDIC_ITERATIONS = imu_cf_pkg::CORDIC_ITERS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [15:0]                  accel_x,
	input  logic signed [15:0]                  accel_y,
	input  logic signed [15:0]                  accel_z,
	input  logic signed [15:0]                  gyro_x,
	input  logic signed [15:0]                  gyro_y,
	input  logic signed [15:0]                  gyro_z,
	// attitude output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [31:0]                  pitch_deg,
	output logic signed [31:0]                  roll_deg,
	output logic signed [31:0]                  yaw_deg,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [imu_cf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [16:0]                         cfg_data
);

	localparam int CW = imu_cf_pkg::CW;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PRE   = 3'd1;  // squares and gyro increments
	localparam logic [2:0] ST_ROOT  = 3'd2;  // magnitude root and pitch cordic
	localparam logic [2:0] ST_ROLL  = 3'd3;  // roll cordic
	localparam logic [2:0] ST_BLEND = 3'd4;  // blend products and yaw
	localparam logic [2:0] ST_OUT   = 3'd5;  // hand over to output register

	logic [2:0] state_q;
	logic [2:0] step_q;

	// configuration
	logic [16:0] alpha_cfg_q;
	logic [15:0] gain_cfg_q;
	logic [16:0] alpha_clamp;

	// captured sample and per-item weights
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [16:0] alpha_q;
	logic [16:0] beta_q;

	// working registers
	logic [imu_cf_pkg::SQ_W-1:0] sq_q;
	logic signed [imu_cf_pkg::INC_W-1:0] inc_q;
	logic signed [imu_cf_pkg::PRED_W-1:0] pred_p_q, pred_r_q;
	logic signed [CW-1:0] acc_p_q, acc_r_q;
	logic signed [imu_cf_pkg::SUM_W-1:0] sum_p_q, sum_r_q;

	// shared multiplier
	logic signed [imu_cf_pkg::MUL_A_W-1:0] mul_a;
	logic signed [imu_cf_pkg::MUL_B_W-1:0] mul_b;
	logic signed [imu_cf_pkg::PROD_W-1:0] prod_q;

	// filter state
	logic signed [31:0] pitch_q, roll_q, yaw_q;

	// output register
	logic out_valid_q;
	logic out_load;
	logic signed [31:0] pitch_out_q, roll_out_q, yaw_out_q;

	// iterative units
	logic cor_start;
	logic signed [CW-1:0] cor_y, cor_x, cor_z;
	imu_cf_pkg::unit_sts_t cor_sts;
	logic sqrt_start;
	logic [imu_cf_pkg::ROOT_W-1:0] sqrt_root;
	imu_cf_pkg::unit_sts_t sqrt_sts;
	logic angles_done;

	assign alpha_clamp = (alpha_cfg_q > imu_cf_pkg::ALPHA_ONE) ? imu_cf_pkg::ALPHA_ONE
		: alpha_cfg_q;
	assign angles_done = sqrt_sts.done && cor_sts.done;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign pitch_deg = pitch_out_q;
	assign roll_deg = roll_out_q;
	assign yaw_deg = yaw_out_q;

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_PRE) begin
			case (step_q)
				3'd0: begin
					mul_a = 18'(ay_q);
					mul_b = 34'(ay_q);
				end
				3'd1: begin
					mul_a = 18'(az_q);
					mul_b = 34'(az_q);
				end
				3'd2: begin
					mul_a = $signed({2'b00, gain_cfg_q});
					mul_b = 34'(gx_q);
				end
				3'd3: begin
					mul_a = $signed({2'b00, gain_cfg_q});
					mul_b = 34'(gy_q);
				end
				3'd4: begin
					mul_a = $signed({2'b00, gain_cfg_q});
					mul_b = 34'(gz_q);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else if (state_q == ST_BLEND) begin
			case (step_q)
				3'd0: begin
					mul_a = $signed({1'b0, alpha_q});
					mul_b = 34'(pred_p_q);
				end
				3'd1: begin
					mul_a = $signed({1'b0, beta_q});
					mul_b = 34'(acc_p_q);
				end
				3'd2: begin
					mul_a = $signed({1'b0, alpha_q});
					mul_b = 34'(pred_r_q);
				end
				3'd3: begin
					mul_a = $signed({1'b0, beta_q});
					mul_b = 34'(acc_r_q);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	// cordic feed: pitch from (ay, az), roll from (-ax, magnitude)
	always_comb begin
		sqrt_start = (state_q == ST_PRE) && (step_q == 3'd5);
		cor_start = sqrt_start || ((state_q == ST_ROOT) && angles_done);
		if (state_q == ST_PRE) begin
			cor_y = {{3{ay_q[15]}}, ay_q, 8'h00};
			cor_x = {{3{az_q[15]}}, az_q, 8'h00};
		end else begin
			cor_y = '0 - {{3{ax_q[15]}}, ax_q, 8'h00};
			cor_x = {3'b000, sqrt_root};
		end
	end

	imu_cf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.rad_in   ({sq_q, 16'h0000}),
		.root_out (sqrt_root),
		.sts      (sqrt_sts)
	);

	imu_cf_cordic #(
		.ITERS (CORDIC_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.y_in   (cor_y),
		.x_in   (cor_x),
		.z_out  (cor_z),
		.sts    (cor_sts)
	);

	// sequencer, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			alpha_cfg_q <= imu_cf_pkg::ALPHA_RESET;
			gain_cfg_q <= imu_cf_pkg::GAIN_RESET;
			pitch_q <= '0;
			roll_q <= '0;
			yaw_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					imu_cf_pkg::REG_BLEND_ALPHA: alpha_cfg_q <= cfg_data;
					imu_cf_pkg::REG_GYRO_GAIN:   gain_cfg_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PRE;
						step_q <= '0;
					end
				end
				ST_PRE: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd5) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (angles_done) begin
						state_q <= ST_ROLL;
					end
				end
				ST_ROLL: begin
					if (cor_sts.done) begin
						state_q <= ST_BLEND;
						step_q <= '0;
					end
				end
				ST_BLEND: begin
					step_q <= step_q + 1'b1;
					case (step_q)
						3'd0: yaw_q <= imu_cf_pkg::sat_add32(yaw_q, inc_q);
						3'd3: pitch_q <= imu_cf_pkg::sat_rnd16(sum_p_q);
						3'd5: begin
							roll_q <= imu_cf_pkg::sat_rnd16(sum_r_q);
							state_q <= ST_OUT;
						end
						default: ;
					endcase
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if ((state_q == ST_IDLE) && in_valid) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			gx_q <= gyro_x;
			gy_q <= gyro_y;
			gz_q <= gyro_z;
			alpha_q <= alpha_clamp;
			beta_q <= imu_cf_pkg::ALPHA_ONE - alpha_clamp;
		end

		if (state_q == ST_PRE) begin
			case (step_q)
				3'd1: sq_q <= prod_q[imu_cf_pkg::SQ_W-1:0];
				3'd2: sq_q <= sq_q + prod_q[imu_cf_pkg::SQ_W-1:0];
				3'd3: inc_q <= imu_cf_pkg::rnd_inc(prod_q);
				3'd4: begin
					pred_p_q <= {pitch_q[31], pitch_q}
						+ {{(imu_cf_pkg::PRED_W-imu_cf_pkg::INC_W){inc_q[imu_cf_pkg::INC_W-1]}},
						inc_q};
					inc_q <= imu_cf_pkg::rnd_inc(prod_q);
				end
				3'd5: begin
					pred_r_q <= {roll_q[31], roll_q}
						+ {{(imu_cf_pkg::PRED_W-imu_cf_pkg::INC_W){inc_q[imu_cf_pkg::INC_W-1]}},
						inc_q};
					inc_q <= imu_cf_pkg::rnd_inc(prod_q);
				end
				default: ;
			endcase
		end

		if ((state_q == ST_ROOT) && angles_done) begin
			acc_p_q <= cor_z;
		end
		if ((state_q == ST_ROLL) && cor_sts.done) begin
			acc_r_q <= cor_z;
		end

		if (state_q == ST_BLEND) begin
			case (step_q)
				3'd1: sum_p_q <= 53'(prod_q);
				3'd2: sum_p_q <= sum_p_q + 53'(prod_q);
				3'd3: sum_r_q <= 53'(prod_q);
				3'd4: sum_r_q <= sum_r_q + 53'(prod_q);
				default: ;
			endcase
		end

		if (out_load) begin
			pitch_out_q <= pitch_q;
			roll_out_q <= roll_q;
			yaw_out_q <= yaw_q;
		end
	end

`ifndef ASSERT_OFF
	// no new item while a shared unit is still iterating
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!cor_sts.busy && !sqrt_sts.busy))
		else $error("item taken while an iterative unit is busy");

	// blend weights of an item in flight sum to one
	a_weights: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ((18'(alpha_q) + 18'(beta_q)) == 18'(imu_cf_pkg::ALPHA_ONE)))
		else $error("blend weights do not sum to one");

	// blending starts only after the roll angle was ready
	a_blend_after_roll: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLEND && step_q == 3'd0) |-> $past(cor_sts.done))
		else $error("blend started before the roll angle");

	// a result appears only from the hand-over state
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside hand-over");
`endif

endmodule

>>> bench/tb.sv
// self-checking bench for the six-axis complementary attitude filter
`timescale 1ns / 1ps

module tb;

	// bench timing
	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 4;      // quiet cycles after the last result before a write
	localparam int END_WAIT = 120;         // wait after the final settle before the run ends
	localparam int HOLD_CYCLES = 400;      // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on any channel
	localparam int MAX_REPORTS = 10;

	// same round count the block uses, capped at the table length
	localparam int CORDIC_ROUNDS = (imu_cf_pkg::CORDIC_ITERS_DEF > imu_cf_pkg::ATAN_LEN)
		? imu_cf_pkg::ATAN_LEN : imu_cf_pkg::CORDIC_ITERS_DEF;

	// one raw sensor item
	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic signed [15:0] gz;
	} imu_reading_t;

	// one attitude item
	typedef struct packed {
		logic signed [31:0] pitch;
		logic signed [31:0] roll;
		logic signed [31:0] yaw;
	} attitude_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] pitch_deg;
	logic signed [31:0] roll_deg;
	logic signed [31:0] yaw_deg;
	logic cfg_valid;
	logic cfg_ready;
	logic [imu_cf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [16:0] cfg_data;

	imu_complementary_attitude_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.gyro_x    (gyro_x),
		.gyro_y    (gyro_y),
		.gyro_z    (gyro_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pitch_deg (pitch_deg),
		.roll_deg  (roll_deg),
		.yaw_deg   (yaw_deg),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// attitude predictor: own copy of registers and angles
	// ------------------------------------------------------------------

	logic [16:0] blend_alpha_q = imu_cf_pkg::ALPHA_RESET;
	logic [15:0] step_gain_q = imu_cf_pkg::GAIN_RESET;
	int pitch_q = 0;
	int roll_q = 0;
	int yaw_q = 0;

	// atan(2^-k) in q16 degrees
	longint atan_q16_tab [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// expected attitude items, oldest first
	attitude_t attitude_due [$];

	bit idle_on = 1'b1;    // random gaps on both sides
	bit hold_req = 1'b0;   // asks the receiver for one long hold-off
	int fail_count = 0;
	int result_count = 0;
	int quiet_cycles = 0;
	attitude_t want_att;

	// signed shift right with round half up; >>> on longint floors
	function automatic longint rnd_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// floor square root, bit by bit
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'h1 << 62;
		while (probe > v)
			probe >>= 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// atan2(y, x) in q16 degrees, vectoring rotations
	function automatic longint vector_angle(input longint y, input longint x);
		longint z;
		longint xs;
		longint ys;
		z = 0;
		// atan2 of the zero vector is taken as zero
		if (x == 0 && y == 0)
			return 0;
		// left half plane folds by a half turn first
		if (x < 0) begin
			z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
			x = -x;
			y = -y;
		end
		for (int k = 0; k < CORDIC_ROUNDS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z += atan_q16_tab[k];
			end else begin
				x = x - ys;
				y = y + xs;
				z -= atan_q16_tab[k];
			end
		end
		return z;
	endfunction

	// alpha-weighted blend, q32 sum back to q16, saturated
	function automatic longint mix(input longint pred, input longint acc, input longint alpha);
		return clamp32(rnd_shift(alpha * pred
			+ (longint'(imu_cf_pkg::ALPHA_ONE) - alpha) * acc, 16));
	endfunction

	// one filter update: moves the bench copy of the angles on
	function automatic attitude_t advance_attitude(input imu_reading_t r);
		longint ax;
		longint ay;
		longint az;
		longint gain;
		longint alpha;
		longint unsigned sq;
		longint mag;
		longint acc_p;
		longint acc_r;
		attitude_t res;
		ax = r.ax;
		ay = r.ay;
		az = r.az;
		gain = longint'(step_gain_q);
		// alpha above one acts as one
		alpha = (blend_alpha_q > imu_cf_pkg::ALPHA_ONE) ? longint'(imu_cf_pkg::ALPHA_ONE)
			: longint'(blend_alpha_q);
		sq = longint'((ay * ay + az * az) << 16);
		mag = longint'(int_sqrt(sq));
		acc_p = vector_angle(ay * 256, az * 256);
		acc_r = vector_angle(-ax * 256, mag);
		// pitch pairs with gyro x, roll with gyro y
		pitch_q = int'(mix(longint'(pitch_q) + rnd_shift(longint'(r.gx) * gain, 8), acc_p, alpha));
		roll_q = int'(mix(longint'(roll_q) + rnd_shift(longint'(r.gy) * gain, 8), acc_r, alpha));
		yaw_q = int'(clamp32(longint'(yaw_q) + rnd_shift(longint'(r.gz) * gain, 8)));
		res.pitch = pitch_q;
		res.roll = roll_q;
		res.yaw = yaw_q;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int pick;
		if (!idle_on)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [15:0] random_axis();
		int pick;
		int v;
		logic [31:0] raw;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			raw = $urandom();
			return raw[15:0];
		end
		if (pick < 85) begin
			v = int'($urandom_range(0, 128)) - 64;
			return v[15:0];
		end
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh8001;
			2: return -16'sd1;
			3: return 16'sd0;
			4: return 16'sd1;
			default: return 16'sh7fff;
		endcase
	endfunction

	function automatic imu_reading_t random_reading();
		imu_reading_t r;
		r.ax = random_axis();
		r.ay = random_axis();
		r.az = random_axis();
		r.gx = random_axis();
		r.gy = random_axis();
		r.gz = random_axis();
		return r;
	endfunction

	function automatic imu_reading_t reading_of(input int ax, input int ay, input int az,
			input int gx, input int gy, input int gz);
		imu_reading_t r;
		r.ax = ax[15:0];
		r.ay = ay[15:0];
		r.az = az[15:0];
		r.gx = gx[15:0];
		r.gy = gy[15:0];
		r.gz = gz[15:0];
		return r;
	endfunction

	// offer one item, wait for its handshake, log what it should produce;
	// entered and left just after a rising edge
	task automatic send_reading(input imu_reading_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		accel_x <= r.ax;
		accel_y <= r.ay;
		accel_z <= r.az;
		gyro_x <= r.gx;
		gyro_y <= r.gy;
		gyro_z <= r.gz;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		attitude_due.push_back(advance_attitude(r));
	endtask

	// stop offering and wait until every expected item has come out
	task automatic settle_block();
		in_valid <= 1'b0;
		while (attitude_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back while the block is idle
	task automatic apply_settings(input logic [16:0] alpha, input logic [16:0] gain);
		settle_block();
		cfg_index <= imu_cf_pkg::REG_BLEND_ALPHA;
		cfg_data <= alpha;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		blend_alpha_q = alpha;
		cfg_index <= imu_cf_pkg::REG_GYRO_GAIN;
		cfg_data <= gain;
		do
			@(posedge clk);
		while (!cfg_ready);
		// only the low sixteen bits of the gain are kept
		step_gain_q = gain[15:0];
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset register values; field extremes, quadrant folds, zero vector
	task automatic test_directed_angles();
		send_reading(reading_of(0, 0, 0, 0, 0, 0));
		send_reading(reading_of(0, 0, 0, 32767, -32768, 1));
		send_reading(reading_of(-32768, 0, 0, 0, 0, 0));
		send_reading(reading_of(32767, 0, 0, 0, 0, 0));
		// x negative with y zero folds to plus half turn
		send_reading(reading_of(0, 0, -1, 0, 0, 0));
		send_reading(reading_of(0, -1, -32768, 0, 0, 0));
		send_reading(reading_of(0, -32768, -32768, -1, -1, -1));
		send_reading(reading_of(0, 32767, 32767, 1, 1, 1));
		send_reading(reading_of(0, 32767, 0, 0, 0, 0));
		send_reading(reading_of(0, -32768, 0, 0, 0, 0));
		send_reading(reading_of(0, 0, 32767, 0, 0, 0));
		send_reading(reading_of(-32768, -32768, -32768, -32768, -32768, -32768));
		send_reading(reading_of(32767, 32767, 32767, 32767, 32767, 32767));
		send_reading(reading_of(1, -1, 1, 0, 0, 0));
		send_reading(reading_of(100, -200, 4096, -1, 2, -3));
		send_reading(reading_of(0, 0, 4096, 16, -16, 300));
		send_reading(reading_of(-4096, 0, 0, 0, 0, 0));
	endtask

	// a run of items under each register setting, extremes first
	task automatic test_register_settings();
		logic [16:0] alpha_set [7];
		logic [16:0] gain_set [7];
		alpha_set = '{17'd0, 17'd65536, 17'd131071, 17'd65537, 17'd32768, 17'd1, 17'd65535};
		gain_set = '{17'd0, 17'd65535, 17'h1ffff, 17'h104d2, 17'd5115, 17'd1, 17'h10000};
		for (int k = 0; k < 7; k++) begin
			apply_settings(alpha_set[k], gain_set[k]);
			repeat (10) send_reading(random_reading());
		end
	endtask

	// full gyro rates with alpha at one drive pitch and yaw into the upper limit
	// and roll into the lower one
	task automatic test_saturation();
		imu_reading_t r;
		apply_settings(imu_cf_pkg::ALPHA_ONE, 17'd65535);
		repeat (150) begin
			r = random_reading();
			r.gx = 16'sh7fff;
			r.gy = 16'sh8000;
			r.gz = 16'sh7fff;
			send_reading(r);
		end
		// alpha above one behaves as one; the angles run on into the limits
		apply_settings(17'h1ffff, 17'd65535);
		repeat (150) begin
			r = random_reading();
			r.gx = 16'sh7fff;
			r.gy = 16'sh8000;
			r.gz = 16'sh7fff;
			send_reading(r);
		end
	endtask

	// receiver holds off while items keep coming, so the block backs up
	task automatic test_backpressure();
		apply_settings(imu_cf_pkg::ALPHA_RESET, {1'b0, imu_cf_pkg::GAIN_RESET});
		idle_on = 1'b0;
		hold_req <= 1'b1;
		repeat (8) send_reading(random_reading());
		idle_on = 1'b1;
	endtask

	// random items in phases, fresh register values between them
	task automatic test_random_readings();
		logic [16:0] alpha;
		logic [16:0] gain;
		for (int phase = 0; phase < 4; phase++) begin
			alpha = ($urandom_range(0, 9) < 7) ? 17'($urandom_range(0, 65536))
				: 17'($urandom_range(0, 131071));
			gain = 17'($urandom_range(0, 131071));
			apply_settings(alpha, gain);
			// one phase runs with no gaps at all
			idle_on = (phase != 2);
			repeat (25) send_reading(random_reading());
		end
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// clock, reset and sequencing
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		accel_x <= '0;
		accel_y <= '0;
		accel_z <= '0;
		gyro_x <= '0;
		gyro_y <= '0;
		gyro_z <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= imu_cf_pkg::REG_BLEND_ALPHA;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_angles();
		test_register_settings();
		test_saturation();
		test_backpressure();
		test_random_readings();

		settle_block();
		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// receiving side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int gap_left;
		gap_left = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				hold_req <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (gap_left > 0) begin
				out_ready <= 1'b0;
				gap_left--;
			end else begin
				out_ready <= 1'b1;
				gap_left = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------

	task automatic check_angle(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("result %0d %s: expected %0d, got %0d", result_count, name, want, got);
		end
	endtask

	// each accepted item is matched against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (attitude_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("result %0d arrived with nothing expected", result_count);
			end else begin
				want_att = attitude_due.pop_front();
				check_angle("pitch_deg", want_att.pitch, pitch_deg);
				check_angle("roll_deg", want_att.roll, roll_deg);
				check_angle("yaw_deg", want_att.yaw, yaw_deg);
			end
		end
	end

	// watchdog: too long with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
